[design/elevator_next_stop_select_assert.svh]
// Assertion macros for the elevator next-stop selector.
`ifndef ELEVATOR_NEXT_STOP_SELECT_ASSERT_SVH
`define ELEVATOR_NEXT_STOP_SELECT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ENSEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ENSEL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ENSEL_ASSERT(label, prop, msg)
`define ENSEL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[design/ensel_pkg.sv]
// Constants and types for the elevator next-stop selector.
package ensel_pkg;

  localparam int FloorCount = 4;
  localparam int CabSlots   = 4;

  localparam int FloorW  = 2;
  localparam int DirW    = 2;
  localparam int CabW    = 3;
  localparam int MaskW   = 3;
  localparam int TargetW = 3;

  // Direction codes
  localparam logic signed [DirW-1:0] DirUp   = 2'sb01;
  localparam logic signed [DirW-1:0] DirDown = 2'sb11;
  localparam logic signed [DirW-1:0] DirStop = 2'sb00;

  // End marker of the cab list, and the result when nothing is pending
  localparam logic signed [CabW-1:0]    CabEnd   = 3'sb111;
  localparam logic signed [TargetW-1:0] NoTarget = 3'sb111;

  typedef logic signed [CabW-1:0] cab_req_t;

  typedef struct packed {
    logic [FloorW-1:0]                car_floor;
    logic signed [DirW-1:0]           travel_dir;
    logic signed [DirW-1:0]           prior_dir;
    logic [CabSlots-1:0][CabW-1:0]    cab_req;
    logic [MaskW-1:0]                 hall_up_mask;
    logic [MaskW-1:0]                 hall_down_mask;
  } query_t;

endpackage

[design/elevator_next_stop_select.sv]
// Elevator next-stop selector: input register, selection logic, result register.
//
// Takes one query per cycle while the result register is not stalled and returns
// its next stop once the transaction has passed the input register and then the
// result register. The selection logic between them decides in a single pass: the
// current floor is served first when a cab request or a hall call that the car
// is not moving against stands there; otherwise a sweep direction comes from
// the cab requests, or from the travel direction (prior direction when stopped),
// and the nearest qualifying floor in that direction, then in the opposite one,
// is chosen. A result of -1 means no request stands. No state is kept between
// queries; while the result register is stalled, the input register still
// holds one more query.
module elevator_next_stop_select (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ensel_pkg::FloorW-1:0]           car_floor_i,
  input  logic signed [ensel_pkg::DirW-1:0]      travel_dir_i,
  input  logic signed [ensel_pkg::DirW-1:0]      prior_dir_i,
  input  logic signed [ensel_pkg::CabW-1:0]      cab_req_0_i,
  input  logic signed [ensel_pkg::CabW-1:0]      cab_req_1_i,
  input  logic signed [ensel_pkg::CabW-1:0]      cab_req_2_i,
  input  logic signed [ensel_pkg::CabW-1:0]      cab_req_3_i,
  input  logic [ensel_pkg::MaskW-1:0]            hall_up_mask_i,
  input  logic [ensel_pkg::MaskW-1:0]            hall_down_mask_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ensel_pkg::TargetW-1:0]   target_floor_o
);
  import ensel_pkg::*;

`include "elevator_next_stop_select_assert.svh"

  query_t                     query_d, query_q;
  logic                       s1_valid_q;
  logic                       s1_move;
  logic                       out_valid_q;
  logic signed [TargetW-1:0]  target_d, target_q;

  logic [FloorW-1:0]          floor;
  logic signed [CabW-1:0]     floor_s;
  logic [CabSlots-1:0]        cab_live;
  logic [FloorCount-1:0]      cab_at, up_call, down_call, req_any;
  logic [FloorCount-1:0]      mask1, mask2;
  logic                       cab_above, cab_below, has_cab, dir_up, go_up;
  logic                       serve_here, found1, found2;
  logic [FloorW-1:0]          hit1, hit2;

  // Gather the port fields into one query
  always_comb begin
    query_d.car_floor      = car_floor_i;
    query_d.travel_dir     = travel_dir_i;
    query_d.prior_dir      = prior_dir_i;
    query_d.cab_req[0]     = cab_req_0_i;
    query_d.cab_req[1]     = cab_req_1_i;
    query_d.cab_req[2]     = cab_req_2_i;
    query_d.cab_req[3]     = cab_req_3_i;
    query_d.hall_up_mask   = hall_up_mask_i;
    query_d.hall_down_mask = hall_down_mask_i;
  end

  // Handshake: advance when the result register is free or being drained
  assign s1_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      query_q <= query_d;
    end
  end

  // Decode floor, cab list and hall calls per floor
  always_comb begin
    logic live;
    if (query_q.car_floor > FloorW'(FloorCount - 1)) begin
      floor = FloorW'(FloorCount - 1);
    end else begin
      floor = query_q.car_floor;
    end
    floor_s = signed'(CabW'(floor));

    live = 1'b1;
    for (int i = 0; i < CabSlots; i++) begin
      live        = live && (cab_req_t'(query_q.cab_req[i]) != CabEnd);
      cab_live[i] = live;
    end

    cab_above = 1'b0;
    cab_below = 1'b0;
    for (int i = 0; i < CabSlots; i++) begin
      if (cab_live[i] && (cab_req_t'(query_q.cab_req[i]) > floor_s)) cab_above = 1'b1;
      if (cab_live[i] && (cab_req_t'(query_q.cab_req[i]) < floor_s)) cab_below = 1'b1;
    end

    for (int f = 0; f < FloorCount; f++) begin
      cab_at[f] = 1'b0;
      for (int i = 0; i < CabSlots; i++) begin
        if (cab_live[i] && (query_q.cab_req[i] == CabW'(f))) cab_at[f] = 1'b1;
      end
      up_call[f]   = 1'b0;
      down_call[f] = 1'b0;
      if (f < FloorCount - 1) up_call[f] = query_q.hall_up_mask[f];
      if (f > 0) down_call[f] = query_q.hall_down_mask[f-1];
      req_any[f] = cab_at[f] | up_call[f] | down_call[f];
    end
  end

  // Choose the sweep direction and the floors each pass may stop at
  always_comb begin
    serve_here = cab_at[floor]
               | ((query_q.travel_dir != DirDown) & up_call[floor])
               | ((query_q.travel_dir != DirUp) & down_call[floor]);
    has_cab = cab_above | cab_below;
    if (query_q.travel_dir != DirStop) begin
      dir_up = (query_q.travel_dir != DirDown);
    end else begin
      dir_up = (query_q.prior_dir != DirDown);
    end
    if (cab_above && !cab_below) begin
      go_up = 1'b1;
    end else if (cab_below && !cab_above) begin
      go_up = 1'b0;
    end else begin
      go_up = dir_up;
    end
    mask2 = req_any;
    if (go_up) begin
      mask1 = cab_at | up_call | ({FloorCount{!has_cab}} & down_call);
    end else begin
      mask1 = cab_at | down_call | ({FloorCount{!has_cab}} & up_call);
    end
  end

  // Scan outward: nearest floor in the sweep direction, then the other way
  always_comb begin
    found1 = 1'b0;
    found2 = 1'b0;
    hit1   = '0;
    hit2   = '0;
    if (go_up) begin
      for (int f = FloorCount - 1; f >= 0; f--) begin
        if (FloorW'(f) > floor && mask1[f]) begin
          found1 = 1'b1;
          hit1   = FloorW'(f);
        end
      end
      for (int f = 0; f < FloorCount; f++) begin
        if (FloorW'(f) < floor && mask2[f]) begin
          found2 = 1'b1;
          hit2   = FloorW'(f);
        end
      end
    end else begin
      for (int f = 0; f < FloorCount; f++) begin
        if (FloorW'(f) < floor && mask1[f]) begin
          found1 = 1'b1;
          hit1   = FloorW'(f);
        end
      end
      for (int f = FloorCount - 1; f >= 0; f--) begin
        if (FloorW'(f) > floor && mask2[f]) begin
          found2 = 1'b1;
          hit2   = FloorW'(f);
        end
      end
    end

    if (serve_here) begin
      target_d = signed'(TargetW'(floor));
    end else if (found1) begin
      target_d = signed'(TargetW'(hit1));
    end else if (found2) begin
      target_d = signed'(TargetW'(hit2));
    end else begin
      target_d = NoTarget;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      target_q <= target_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_floor_o = target_q;

  // Checks
  `ENSEL_ASSERT(a_move_fills_out, s1_valid_q && s1_move |=> out_valid_o, "query lost on transfer")
  `ENSEL_ASSERT(a_stall_holds_query, s1_valid_q && !s1_move |=> s1_valid_q && $stable(query_q), "stalled query changed")
  `ENSEL_ASSERT(a_target_has_request, s1_valid_q && (target_d != NoTarget) |-> req_any[target_d[FloorW-1:0]], "target floor without request")
  `ENSEL_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_q |-> in_ready_o, "not ready while input register empty")

endmodule
